// ===== hdl/rplm_pkg.sv =====
// Shared constants, codes and types of the reference picture list modifier.
`default_nettype none
package rplm_pkg;

  localparam int MAX_REFS   = 32;
  localparam int LIST_SLOTS = MAX_REFS + 1;
  localparam int SLOT_AW    = $clog2(LIST_SLOTS);

  localparam int REF_IW  = 5;
  localparam int PIC_W   = 17;
  localparam int FRAME_W = 16;
  localparam int MAXF_W  = 17;
  localparam int ARM_W   = 5;
  localparam int DIFF_W  = 16;
  localparam int LTN_W   = 5;
  localparam int REQ_W   = 2;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 17;

  typedef enum logic [REQ_W-1:0] {
    REQ_SUB  = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_LONG = 2'd2,
    REQ_END  = 2'd3
  } req_t;

  localparam logic [CFG_AW-1:0] CFG_MAX_FRAME_NUM  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CUR_FRAME_NUM  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ACTIVE_MINUS1  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_MOD_ENABLE     = 2'd3;

  typedef struct packed {
    logic             present;
    logic             lt;
    logic [PIC_W-1:0] pic;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_WRAP,
    ST_PIC,
    ST_SHIFT,
    ST_INS,
    ST_COMPACT,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_DEF_OUT
  } rplm_state_t;

  typedef struct packed {
    logic latch_in;
    logic st_sum;
    logic st_wrap;
    logic st_pic;
    logic shift_init;
    logic shift_step;
    logic ins_write;
    logic compact_step;
    logic emit_init;
    logic emit_rd;
    logic emit_next;
    logic out_default;
    logic new_slice;
  } rplm_cmd_t;

  typedef struct packed {
    logic mod_en;
    logic idx_full;
    logic shift_done;
    logic compact_done;
    logic emit_last;
  } rplm_sts_t;

endpackage
`default_nettype wire

// ===== hdl/rplm_ctrl.sv =====
// Command sequencer of the reference picture list modifier.
`default_nettype none
module rplm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [rplm_pkg::REQ_W-1:0] in_req,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire rplm_pkg::rplm_sts_t sts,
  output rplm_pkg::rplm_cmd_t      cmd
);
  import rplm_pkg::*;

  rplm_state_t state_r, state_nxt;
  req_t        req;

  assign req = req_t'(in_req);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          case (req)
            REQ_END: begin
              if (!sts.mod_en) begin
                state_nxt = ST_DEF_OUT;
              end else begin
                cmd.emit_init = 1'b1;
                state_nxt     = ST_EMIT_RD;
              end
            end
            REQ_LONG: begin
              if (sts.mod_en && !sts.idx_full) begin
                cmd.shift_init = 1'b1;
                state_nxt      = ST_SHIFT;
              end
            end
            default: begin
              if (sts.mod_en) state_nxt = ST_SUM;
            end
          endcase
        end
      end
      ST_SUM: begin
        cmd.st_sum = 1'b1;
        state_nxt  = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.st_wrap = 1'b1;
        state_nxt   = ST_PIC;
      end
      ST_PIC: begin
        cmd.st_pic = 1'b1;
        // prediction is updated even when the list is full
        if (sts.idx_full) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt      = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = ST_INS;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_INS: begin
        cmd.ins_write = 1'b1;
        state_nxt     = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (sts.compact_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.compact_step = 1'b1;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.emit_last) begin
            cmd.new_slice = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = ST_EMIT_RD;
          end
        end
      end
      ST_DEF_OUT: begin
        out_tvalid      = 1'b1;
        cmd.out_default = 1'b1;
        if (out_tready) begin
          cmd.new_slice = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/rplm_datapath.sv =====
// List memory, prediction arithmetic, pass counters and registers of the list modifier.
`default_nettype none
module rplm_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rplm_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [rplm_pkg::CFG_DW-1:0]  cfg_wdata,
  input  wire logic [rplm_pkg::REQ_W-1:0]   in_req,
  input  wire logic [rplm_pkg::DIFF_W-1:0]  in_diff,
  input  wire logic [rplm_pkg::LTN_W-1:0]   in_ltn,
  input  wire rplm_pkg::rplm_cmd_t          cmd,
  output rplm_pkg::rplm_sts_t               sts,
  output logic [rplm_pkg::REF_IW-1:0]       out_ref_index,
  output logic                              out_present,
  output logic                              out_is_long_term,
  output logic signed [rplm_pkg::PIC_W-1:0] out_pic_num,
  output logic                              out_last
);
  import rplm_pkg::*;

  // configuration
  logic [MAXF_W-1:0]  max_r;
  logic [FRAME_W-1:0] cur_r;
  logic [ARM_W-1:0]   arm1_r;
  logic               en_r;

  // list state
  logic [PIC_W:0]          mem [0:LIST_SLOTS-1];
  logic [LIST_SLOTS-1:0]   present_r;
  slot_t                   rd_q_r;
  slot_t                   ins_r;
  logic [SLOT_AW-1:0]      idx_r;
  logic [FRAME_W-1:0]      pred_r;

  // pass control
  logic [SLOT_AW-1:0] c_r;
  logic [SLOT_AW-1:0] n_r;
  logic [SLOT_AW-1:0] wb_addr_r;
  logic               wb_v_r;
  logic [REF_IW-1:0]  k_r;

  // short-term arithmetic
  logic [DIFF_W-1:0]        diff_r;
  logic                     add_r;
  logic signed [DIFF_W+1:0] sum_r;
  logic [FRAME_W-1:0]       nw16_r;

  logic [SLOT_AW-1:0]       len_raw, len;
  logic                     c_gt_idx, c_le_len, match;
  logic                     we, re;
  logic [SLOT_AW-1:0]       waddr, raddr;
  slot_t                    wdata;
  logic [FRAME_W-1:0]       pred_sel;
  logic signed [DIFF_W+1:0] pred_ext, d_ext;
  logic signed [DIFF_W+2:0] s_ext, m_ext, wrapped;
  logic [PIC_W-1:0]         pic_calc;

  assign len_raw  = SLOT_AW'(arm1_r) + 1'b1;
  assign len      = (len_raw > SLOT_AW'(MAX_REFS)) ? SLOT_AW'(MAX_REFS) : len_raw;
  assign c_gt_idx = (c_r > idx_r);
  assign c_le_len = (c_r <= len);
  assign match    = rd_q_r.present && (rd_q_r.lt == ins_r.lt) && (rd_q_r.pic == ins_r.pic);

  assign sts.mod_en       = en_r;
  assign sts.idx_full     = (idx_r >= len);
  assign sts.shift_done   = !c_gt_idx && !wb_v_r;
  assign sts.compact_done = !c_le_len && !wb_v_r;
  assign sts.emit_last    = ((SLOT_AW'(k_r) + 1'b1) == len);

  // one write and one read per cycle; sources never overlap
  assign we = cmd.ins_write || (cmd.shift_step && wb_v_r) ||
              (cmd.compact_step && wb_v_r && !match);
  assign waddr = cmd.ins_write ? idx_r : (cmd.shift_step ? wb_addr_r : n_r);
  assign wdata = cmd.ins_write ? ins_r : rd_q_r;
  assign re    = (cmd.shift_step && c_gt_idx) || (cmd.compact_step && c_le_len) || cmd.emit_rd;
  assign raddr = cmd.shift_step ? SLOT_AW'(c_r - 1'b1) :
                 (cmd.compact_step ? c_r : SLOT_AW'(k_r));

  assign pred_sel = (idx_r == '0) ? cur_r : pred_r;
  assign pred_ext = {2'b00, pred_sel};
  assign d_ext    = {2'b00, diff_r} + 1'b1;
  assign s_ext    = {sum_r[DIFF_W+1], sum_r};
  assign m_ext    = {2'b00, max_r};

  always_comb begin
    wrapped = s_ext;
    if (add_r) begin
      if (s_ext >= m_ext) wrapped = s_ext - m_ext;
    end else begin
      if (sum_r[DIFF_W+1]) wrapped = s_ext + m_ext;
    end
  end

  assign pic_calc = (nw16_r > cur_r) ? ({1'b0, nw16_r} - max_r) : {1'b0, nw16_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= MAXF_W'(16);
      cur_r  <= '0;
      arm1_r <= '0;
      en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_FRAME_NUM: max_r  <= cfg_wdata[MAXF_W-1:0];
        CFG_CUR_FRAME_NUM: cur_r  <= cfg_wdata[FRAME_W-1:0];
        CFG_ACTIVE_MINUS1: arm1_r <= cfg_wdata[ARM_W-1:0];
        CFG_MOD_ENABLE:    en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wdata.lt, wdata.pic};
    if (re) rd_q_r <= '{present: present_r[raddr], lt: mem[raddr][PIC_W],
                        pic: mem[raddr][PIC_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.new_slice) begin
      present_r <= '0;
    end else if (we) begin
      present_r[waddr] <= wdata.present;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pred_r <= '0;
      wb_v_r <= 1'b0;
    end else begin
      if (cmd.new_slice) begin
        idx_r  <= '0;
        pred_r <= cur_r;
      end
      if (cmd.st_wrap) pred_r <= wrapped[FRAME_W-1:0];
      if (cmd.ins_write) idx_r <= idx_r + 1'b1;
      if (cmd.shift_init || cmd.ins_write) wb_v_r <= 1'b0;
      if (cmd.shift_step) wb_v_r <= c_gt_idx;
      if (cmd.compact_step) wb_v_r <= c_le_len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      diff_r <= in_diff;
      add_r  <= (req_t'(in_req) == REQ_ADD);
      if (req_t'(in_req) == REQ_LONG) ins_r <= '{present: 1'b1, lt: 1'b1, pic: PIC_W'(in_ltn)};
    end
    if (cmd.st_sum) sum_r <= add_r ? (pred_ext + d_ext) : (pred_ext - d_ext);
    if (cmd.st_wrap) nw16_r <= wrapped[FRAME_W-1:0];
    if (cmd.st_pic) ins_r <= '{present: 1'b1, lt: 1'b0, pic: pic_calc};
    if (cmd.shift_init) c_r <= len;
    if (cmd.shift_step && c_gt_idx) begin
      c_r       <= c_r - 1'b1;
      wb_addr_r <= c_r;
    end
    if (cmd.ins_write) begin
      c_r <= idx_r + 1'b1;
      n_r <= idx_r + 1'b1;
    end
    if (cmd.compact_step) begin
      if (c_le_len) c_r <= c_r + 1'b1;
      if (wb_v_r && !match) n_r <= n_r + 1'b1;
    end
    if (cmd.emit_init) k_r <= '0;
    if (cmd.emit_next) k_r <= k_r + 1'b1;
  end

  always_comb begin
    if (cmd.out_default) begin
      out_ref_index    = '0;
      out_present      = 1'b1;
      out_is_long_term = 1'b0;
      out_pic_num      = {1'b0, cur_r};
      out_last         = 1'b1;
    end else begin
      out_ref_index    = k_r;
      out_present      = rd_q_r.present;
      out_is_long_term = rd_q_r.present && rd_q_r.lt;
      out_pic_num      = rd_q_r.present ? rd_q_r.pic : '0;
      out_last         = sts.emit_last;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ref_pic_list_modifier.sv =====
// Top level of the reference picture list modifier: sequencer plus datapath.
//
// Input words carry a command: in_tuser is the request type (subtract, add,
// long-term insert, end), in_tdata the difference and the long-term number.
// Output words carry list entries: out_tdata the index and picture number,
// out_tuser the present and long-term flags, out_tlast the final entry.
// The cfg port writes the four registers; the user must write them only while idle (not enforced by the block).
// One command at a time: in_tready is high only between commands.
// A short-term command runs its arithmetic through the sum, wrap and picture
// number states; an insertion then runs a shift pass over the slots behind the
// insertion index, an insert write, and then a compaction pass over the same
// slots of the list memory.
// An end command emits each word by a memory read, then the output register
// state, while out_tready stays high; a stall holds the word in place.
// With modification off, end emits one default word.
// Synchronous reset empties the list at once through the present bits and
// loads the register defaults; no clearing pass is needed.
`default_nettype none
module ref_pic_list_modifier (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // abs_diff_minus1[15:0], long_term_num[20:16]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // ref_index[4:0], pic_num[21:5]
  output logic [1:0]       out_tuser,  // present[0], is_long_term[1]
  output logic             out_tlast
);
  import rplm_pkg::*;

  rplm_cmd_t                cmd;
  rplm_sts_t                sts;
  logic [REF_IW-1:0]        ref_index;
  logic                     present;
  logic                     is_long_term;
  logic signed [PIC_W-1:0]  pic_num;

  rplm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rplm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_req           (in_tuser),
    .in_diff          (in_tdata[15:0]),
    .in_ltn           (in_tdata[20:16]),
    .cmd              (cmd),
    .sts              (sts),
    .out_ref_index    (ref_index),
    .out_present      (present),
    .out_is_long_term (is_long_term),
    .out_pic_num      (pic_num),
    .out_last         (out_tlast)
  );

  assign out_tdata = {2'b00, pic_num, ref_index};
  assign out_tuser = {is_long_term, present};

endmodule
`default_nettype wire
